// ----- design/rv64i_decode_execute_top_defines.svh -----
// assertion macros for the rv64i decode and execute unit
`ifndef RV64I_DECODE_EXECUTE_TOP_DEFINES_SVH
`define RV64I_DECODE_EXECUTE_TOP_DEFINES_SVH

// same-cycle implication, quiet during reset
`define RVDE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define RVDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rvde_pkg.sv -----
// shared types and encodings of the rv64i decode and execute unit
package rvde_pkg;

  localparam logic [31:0] WORD_HALT = 32'hfeedfeed;
  localparam logic [31:0] WORD_NOP  = 32'h00000013;

  localparam logic [6:0] OPC_OP        = 7'h33;
  localparam logic [6:0] OPC_OP_IMM    = 7'h13;
  localparam logic [6:0] OPC_OP_32     = 7'h3b;
  localparam logic [6:0] OPC_OP_IMM_32 = 7'h1b;
  localparam logic [6:0] OPC_LOAD      = 7'h03;
  localparam logic [6:0] OPC_STORE     = 7'h23;
  localparam logic [6:0] OPC_BRANCH    = 7'h63;
  localparam logic [6:0] OPC_JALR      = 7'h67;
  localparam logic [6:0] OPC_JAL       = 7'h6f;
  localparam logic [6:0] OPC_LUI       = 7'h37;
  localparam logic [6:0] OPC_AUIPC     = 7'h17;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [2:0] F3_LWU  = 3'd6;
  localparam logic [2:0] F3_BAD_LOAD = 3'd7;
  localparam logic [2:0] F3_SD   = 3'd3;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [5:0] F6_BASE = 6'h00;
  localparam logic [5:0] F6_ALT  = 6'h10;

  localparam int unsigned IN_DATA_W   = 224;
  localparam int unsigned OUT_DATA_W  = 208;
  localparam int unsigned OUT_USER_W  = 3;

  typedef struct packed {
    logic        legal;
    logic        halt;
    logic        nop;
    logic        writes_dest;
    logic [4:0]  dest_reg;
    logic [63:0] alu_value;
    logic [63:0] next_pc;
    logic        mem_read;
    logic        mem_write;
    logic [63:0] mem_address;
    logic [1:0]  access_size;
    logic        load_signed;
  } rvde_result_t;

endpackage

// ----- design/rvde_exec.sv -----
// decode, legality check and execute logic for one instruction word
module rvde_exec import rvde_pkg::*; (
  input  logic [31:0]  instruction_word,
  input  logic [63:0]  pc,
  input  logic [63:0]  rs1_value,
  input  logic [63:0]  rs2_value,
  output rvde_result_t res
);

  logic [6:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [5:0]  f6;
  logic [63:0] iimm, simm, bimm, jimm, uimm;
  logic [63:0] pc4;
  logic [63:0] y;
  logic [5:0]  sh6;
  logic [4:0]  sh5;
  logic [31:0] w32;
  logic        take;
  logic        legal, wr;
  logic        is_op, is_op32;

  assign op  = instruction_word[6:0];
  assign rd  = instruction_word[11:7];
  assign f3  = instruction_word[14:12];
  assign f7  = instruction_word[31:25];
  assign f6  = instruction_word[31:26];
  assign iimm = {{52{instruction_word[31]}}, instruction_word[31:20]};
  assign simm = {{52{instruction_word[31]}}, instruction_word[31:25], instruction_word[11:7]};
  assign bimm = {{51{instruction_word[31]}}, instruction_word[31], instruction_word[7],
                 instruction_word[30:25], instruction_word[11:8], 1'b0};
  assign jimm = {{43{instruction_word[31]}}, instruction_word[31], instruction_word[19:12],
                 instruction_word[20], instruction_word[30:21], 1'b0};
  assign uimm = {{32{instruction_word[31]}}, instruction_word[31:12], 12'h000};
  assign pc4  = pc + 64'd4;

  assign is_op   = (op == OPC_OP);
  assign is_op32 = (op == OPC_OP_32);
  assign y   = (is_op || is_op32) ? rs2_value : iimm;
  assign sh6 = (is_op || is_op32) ? rs2_value[5:0] : instruction_word[25:20];
  assign sh5 = sh6[4:0];

  always_comb begin
    case (f3)
      F3_ADD:  w32 = (is_op32 && f7 == F7_ALT) ? rs1_value[31:0] - y[31:0]
                                                : rs1_value[31:0] + y[31:0];
      F3_SLL:  w32 = rs1_value[31:0] << sh5;
      default: w32 = instruction_word[30] ? 32'($signed(rs1_value[31:0]) >>> sh5)
                                          : rs1_value[31:0] >> sh5;
    endcase
  end

  always_comb begin
    case (f3)
      F3_BEQ:  take = (rs1_value == rs2_value);
      F3_BNE:  take = (rs1_value != rs2_value);
      F3_BLT:  take = ($signed(rs1_value) < $signed(rs2_value));
      F3_BGE:  take = !($signed(rs1_value) < $signed(rs2_value));
      F3_BLTU: take = (rs1_value < rs2_value);
      default: take = (rs1_value >= rs2_value);
    endcase
  end

  always_comb begin
    res = '0;
    res.next_pc = pc4;
    legal = 1'b0;
    wr = 1'b0;
    if (instruction_word == WORD_HALT) begin
      legal = 1'b1;
      res.halt = 1'b1;
    end else if (instruction_word == WORD_NOP) begin
      legal = 1'b1;
      res.nop = 1'b1;
    end else begin
      case (op)
        OPC_OP, OPC_OP_IMM: begin
          if (is_op) begin
            legal = (f7 == F7_BASE) || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SRL));
          end else begin
            legal = !(f3 == F3_SLL && f6 != F6_BASE) &&
                    !(f3 == F3_SRL && f6 != F6_BASE && f6 != F6_ALT);
          end
          wr = legal;
          if (legal) begin
            case (f3)
              F3_ADD:  res.alu_value = (is_op && f7 == F7_ALT) ? rs1_value - y
                                                                : rs1_value + y;
              F3_SLL:  res.alu_value = rs1_value << sh6;
              F3_SLT:  res.alu_value = {63'd0, $signed(rs1_value) < $signed(y)};
              F3_SLTU: res.alu_value = {63'd0, rs1_value < y};
              F3_XOR:  res.alu_value = rs1_value ^ y;
              F3_SRL:  res.alu_value = instruction_word[30]
                                       ? 64'($signed(rs1_value) >>> sh6)
                                       : rs1_value >> sh6;
              F3_OR:   res.alu_value = rs1_value | y;
              default: res.alu_value = rs1_value & y;
            endcase
          end
        end
        OPC_OP_32, OPC_OP_IMM_32: begin
          if (is_op32) begin
            legal = (f3 == F3_ADD || f3 == F3_SLL || f3 == F3_SRL) &&
                    (f7 == F7_BASE || (f7 == F7_ALT && f3 != F3_SLL));
          end else begin
            legal = !(f3 == F3_SLL && f7 != F7_BASE) &&
                    !(f3 == F3_SRL && f7 != F7_BASE && f7 != F7_ALT) &&
                    (f3 == F3_ADD || f3 == F3_SLL || f3 == F3_SRL);
          end
          wr = legal;
          if (legal) begin
            res.alu_value = {{32{w32[31]}}, w32};
          end
        end
        OPC_LOAD: begin
          if (f3 != F3_BAD_LOAD) begin
            legal = 1'b1;
            wr = 1'b1;
            res.mem_read = 1'b1;
            res.mem_address = rs1_value + iimm;
            res.access_size = f3[1:0];
            res.load_signed = (f3 < F3_SLTU);
          end
        end
        OPC_STORE: begin
          if (f3 <= F3_SD) begin
            legal = 1'b1;
            res.mem_write = 1'b1;
            res.mem_address = rs1_value + simm;
            res.access_size = f3[1:0];
          end
        end
        OPC_BRANCH: begin
          if (f3 != F3_SLT && f3 != F3_SLTU) begin
            legal = 1'b1;
            if (take) begin
              res.next_pc = pc + bimm;
            end
          end
        end
        OPC_JALR: begin
          if (f3 == F3_ADD) begin
            legal = 1'b1;
            wr = 1'b1;
            res.alu_value = pc4;
            res.next_pc = (rs1_value + iimm) & ~64'd1;
          end
        end
        OPC_JAL: begin
          legal = 1'b1;
          wr = 1'b1;
          res.alu_value = pc4;
          res.next_pc = pc + jimm;
        end
        OPC_LUI: begin
          legal = 1'b1;
          wr = 1'b1;
          res.alu_value = uimm;
        end
        OPC_AUIPC: begin
          legal = 1'b1;
          wr = 1'b1;
          res.alu_value = pc + uimm;
        end
        default: begin
          legal = 1'b0;
        end
      endcase
    end
    res.legal = legal;
    res.writes_dest = wr && (rd != 5'd0);
    res.dest_reg = (wr && (rd != 5'd0)) ? rd : 5'd0;
  end

endmodule

// ----- design/rv64i_decode_execute_top.sv -----
// RV64I decode and execute unit: one instruction word in, one result word out.
// Each accepted word is held in an input register, decoded and executed by a
// single pass of combinational logic (64-bit adders, comparators and shifters),
// and captured in a result register, which holds it until the result side takes it;
// throughput is one word per cycle while the result side keeps taking. The result
// register lets the next word be taken while a finished result still waits; the
// data registers need no reset-time clearing, only the valid flags are reset.
module rv64i_decode_execute_top import rvde_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // instruction_word, pc, rs1_value, rs2_value
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // writes_dest, dest_reg, alu_value, next_pc, mem_read, mem_write, mem_address,
  // access_size, load_signed, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // legal, halt, nop
  output logic [OUT_USER_W-1:0] out_tuser
);

`include "rv64i_decode_execute_top_defines.svh"

  logic                 s1_v_r, s1_v_nxt;
  logic [IN_DATA_W-1:0] s1_data_r, s1_data_nxt;
  logic                 out_v_r, out_v_nxt;
  rvde_result_t         res_r, res_nxt;
  rvde_result_t         exec_res;
  logic                 out_load;
  logic                 s1_load;

  assign out_load  = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || out_load;
  assign s1_load   = in_tvalid && in_tready;

  rvde_exec u_exec (
    .instruction_word (s1_data_r[31:0]),
    .pc               (s1_data_r[95:32]),
    .rs1_value        (s1_data_r[159:96]),
    .rs2_value        (s1_data_r[223:160]),
    .res              (exec_res)
  );

  always_comb begin
    s1_v_nxt    = s1_v_r;
    s1_data_nxt = s1_data_r;
    out_v_nxt   = out_v_r;
    res_nxt     = res_r;
    if (out_load) begin
      out_v_nxt = s1_v_r;
      res_nxt   = exec_res;
      s1_v_nxt  = 1'b0;
    end
    if (s1_load) begin
      s1_v_nxt    = 1'b1;
      s1_data_nxt = in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_data_r <= s1_data_nxt;
    res_r     <= res_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = {res_r.nop, res_r.halt, res_r.legal};
  assign out_tdata  = {5'd0, res_r.load_signed, res_r.access_size, res_r.mem_address,
                       res_r.mem_write, res_r.mem_read, res_r.next_pc, res_r.alu_value,
                       res_r.dest_reg, res_r.writes_dest};

  `RVDE_ASSERT_NOW(a_illegal_quiet, clk, rst_n, out_v_r && !res_r.legal,
    !res_r.writes_dest && !res_r.mem_read && !res_r.mem_write, "illegal word has side effects")
  `RVDE_ASSERT_NOW(a_one_access, clk, rst_n, out_v_r, !(res_r.mem_read && res_r.mem_write),
    "load and store at once")
  `RVDE_ASSERT_NOW(a_full_stall, clk, rst_n, s1_v_r && out_v_r && !out_tready, !in_tready,
    "word taken into a full input register")
  `RVDE_ASSERT_NEXT(a_word_moves, clk, rst_n, s1_v_r && out_load, out_v_r,
    "executed word lost before the result register")

endmodule
